FILE: hw/rtl/tpl_pkg.sv
// Package for the triangle primitive assembler.
// Holds codes, default sizes and the queue head control type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpl_pkg;

  // Default width of one coordinate word.
  localparam int COORD_WIDTH_DEFAULT = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Command codes carried by an input word.
  localparam logic CMD_BEGIN  = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  // Primitive type codes.
  localparam logic [1:0] MODE_TRIANGLES = 2'd0;
  localparam logic [1:0] MODE_FAN       = 2'd1;
  localparam logic [1:0] MODE_STRIP     = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // Control side of the queue head as seen by the back.
  typedef struct packed {
    logic valid;   // an entry is waiting
    logic single;  // entry emits one vertex (slot c) instead of three
  } tpl_head_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tpl_if.sv
// Channel interfaces of the triangle primitive assembler.
// Depends on tpl_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface tpl_in_if #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [1:0]                    prim_type;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;

  modport source (output valid, cmd, prim_type, vertex_x, vertex_y, input ready);
  modport sink   (input valid, cmd, prim_type, vertex_x, vertex_y, output ready);
endinterface

interface tpl_out_if #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          last;

  modport source (output valid, out_x, out_y, last, input ready);
  modport sink   (input valid, out_x, out_y, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tpl_front.sv
// Front of the assembler: accepts input words, tracks the primitive state
// and turns each emitting vertex into a queue entry. Depends on tpl_pkg and tpl_if.
`timescale 1ns / 1ps
`default_nettype none

module tpl_front #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  tpl_in_if.sink                        in_ch,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output logic                          push_single,
  output logic [2*COORD_WIDTH-1:0]      push_a,
  output logic [2*COORD_WIDTH-1:0]      push_b,
  output logic [2*COORD_WIDTH-1:0]      push_c
);

  localparam int VW = 2 * COORD_WIDTH;

  logic [1:0]    prim_mode;
  logic          fan_first_pending;
  logic          fan_second_pending;
  logic          strip_first_pending;
  logic          strip_second_pending;
  logic          strip_odd;
  logic [VW-1:0] origin_vertex;
  logic [VW-1:0] prev_vertex;
  logic [VW-1:0] older_vertex;

  logic [VW-1:0] vtx;
  logic          accept;
  logic          emits;

  assign vtx          = {in_ch.vertex_y, in_ch.vertex_x};
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid && push_ready;

  // Decide what a vertex word produces in the current mode.
  always_comb begin
    emits       = 1'b0;
    push_single = 1'b0;
    push_a      = origin_vertex;
    push_b      = prev_vertex;
    push_c      = vtx;
    unique case (prim_mode)
      tpl_pkg::MODE_TRIANGLES: begin
        emits       = 1'b1;
        push_single = 1'b1;
      end
      tpl_pkg::MODE_FAN: begin
        emits = !fan_first_pending && !fan_second_pending;
      end
      tpl_pkg::MODE_STRIP: begin
        emits  = !strip_first_pending && !strip_second_pending;
        push_a = strip_odd ? prev_vertex : older_vertex;
        push_b = strip_odd ? older_vertex : prev_vertex;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  assign push_valid = in_ch.valid && (in_ch.cmd == tpl_pkg::CMD_VERTEX) && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_mode            <= tpl_pkg::MODE_NONE;
      fan_first_pending    <= 1'b0;
      fan_second_pending   <= 1'b0;
      strip_first_pending  <= 1'b0;
      strip_second_pending <= 1'b0;
      strip_odd            <= 1'b0;
      origin_vertex        <= '0;
      prev_vertex          <= '0;
      older_vertex         <= '0;
    end else if (accept) begin
      if (in_ch.cmd == tpl_pkg::CMD_BEGIN) begin
        prim_mode <= in_ch.prim_type;
        if (in_ch.prim_type == tpl_pkg::MODE_FAN) begin
          fan_first_pending  <= 1'b1;
          fan_second_pending <= 1'b0;
        end else if (in_ch.prim_type == tpl_pkg::MODE_STRIP) begin
          strip_first_pending  <= 1'b1;
          strip_second_pending <= 1'b0;
          strip_odd            <= 1'b0;
        end
      end else begin
        unique case (prim_mode)
          tpl_pkg::MODE_FAN: begin
            if (fan_first_pending) begin
              origin_vertex      <= vtx;
              fan_first_pending  <= 1'b0;
              fan_second_pending <= 1'b1;
            end else begin
              fan_second_pending <= 1'b0;
              prev_vertex        <= vtx;
            end
          end
          tpl_pkg::MODE_STRIP: begin
            if (strip_first_pending) begin
              older_vertex         <= vtx;
              strip_first_pending  <= 1'b0;
              strip_second_pending <= 1'b1;
            end else if (strip_second_pending) begin
              prev_vertex          <= vtx;
              strip_second_pending <= 1'b0;
            end else begin
              older_vertex <= prev_vertex;
              prev_vertex  <= vtx;
              strip_odd    <= !strip_odd;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpl_queue.sv
// Short queue of triangle entries between the front and the back.
// Depends on tpl_pkg for its depth and the head control type.
`timescale 1ns / 1ps
`default_nettype none

module tpl_queue #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push_valid,
  output logic                             push_ready,
  input  wire logic                        push_single,
  input  wire logic [2*COORD_WIDTH-1:0]    push_a,
  input  wire logic [2*COORD_WIDTH-1:0]    push_b,
  input  wire logic [2*COORD_WIDTH-1:0]    push_c,
  output tpl_pkg::tpl_head_ctl_t           head,
  output logic [2*COORD_WIDTH-1:0]         head_a,
  output logic [2*COORD_WIDTH-1:0]         head_b,
  output logic [2*COORD_WIDTH-1:0]         head_c,
  input  wire logic                        pop
);

  localparam int VW    = 2 * COORD_WIDTH;
  localparam int DEPTH = tpl_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [VW-1:0] slot_a [DEPTH];
  logic [VW-1:0] slot_b [DEPTH];
  logic [VW-1:0] slot_c [DEPTH];
  logic          slot_single [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready  = (count != FULL_CNT);
  assign do_push     = push_valid && push_ready;
  assign do_pop      = pop && head.valid;

  assign head.valid  = (count != '0);
  assign head.single = slot_single[rd_ptr];
  assign head_a      = slot_a[rd_ptr];
  assign head_b      = slot_b[rd_ptr];
  assign head_c      = slot_c[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_a[wr_ptr]      <= push_a;
      slot_b[wr_ptr]      <= push_b;
      slot_c[wr_ptr]      <= push_c;
      slot_single[wr_ptr] <= push_single;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpl_back.sv
// Back of the assembler: walks the queue head one vertex per cycle when not
// stalled into a registered output word. Depends on tpl_pkg and tpl_if.
`timescale 1ns / 1ps
`default_nettype none

module tpl_back #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tpl_pkg::tpl_head_ctl_t      head,
  input  wire logic [2*COORD_WIDTH-1:0]    head_a,
  input  wire logic [2*COORD_WIDTH-1:0]    head_b,
  input  wire logic [2*COORD_WIDTH-1:0]    head_c,
  output logic                             pop,
  tpl_out_if.source                        out_ch
);

  localparam int VW = 2 * COORD_WIDTH;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  logic [1:0]    phase;
  logic [VW-1:0] sel_vtx;
  logic          sel_last;
  logic          out_free;
  logic          out_valid;
  logic          out_last;
  logic [VW-1:0] out_vtx;

  // Pick the vertex of the head entry that goes out next.
  always_comb begin
    sel_vtx  = head_c;
    sel_last = 1'b1;
    if (!head.single) begin
      unique case (phase)
        PH_A: begin
          sel_vtx  = head_a;
          sel_last = 1'b0;
        end
        PH_B: begin
          sel_vtx  = head_b;
          sel_last = 1'b0;
        end
        default: begin
          sel_vtx  = head_c;
          sel_last = 1'b1;
        end
      endcase
    end
  end

  assign out_free = !out_valid || out_ch.ready;
  assign pop      = out_free && head.valid && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_A;
    end else if (out_free) begin
      out_valid <= head.valid;
      if (head.valid) begin
        phase <= sel_last ? PH_A : ((phase == PH_A) ? PH_B : PH_C);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && head.valid) begin
      out_vtx  <= sel_vtx;
      out_last <= sel_last;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.out_x = out_vtx[COORD_WIDTH-1:0];
  assign out_ch.out_y = out_vtx[VW-1:COORD_WIDTH];
  assign out_ch.last  = out_last;

endmodule

`default_nettype wire

FILE: hw/rtl/triangle_primitive_to_list.sv
// Top level of the triangle primitive assembler: front, queue and back.
// Depends on tpl_pkg, tpl_if, tpl_front, tpl_queue and tpl_back.
//
//   Channel   Dir   Word                                  Accepted when
//   in_ch     in    cmd, prim_type, vertex_x, vertex_y    valid && ready
//   out_ch    out   out_x, out_y, last                    valid && ready
//
// Input words are taken at one per cycle while the two-entry queue has room.
// A begin word or a vertex that emits nothing leaves no trace on the output. Each
// emitted triangle takes three words on the single output port and a pass-through
// vertex one; the output port sets the sustained rate. An emitting vertex is written
// into a queue slot and then into the output register before it shows on the output.
// Reset is synchronous and leaves the block in the unsupported mode with an
// empty queue. Either side may stall at will; the queue absorbs the slip.
`timescale 1ns / 1ps
`default_nettype none

module triangle_primitive_to_list #(
  parameter int COORD_WIDTH = tpl_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tpl_in_if.sink      in_ch,
  tpl_out_if.source   out_ch
);

  localparam int VW = 2 * COORD_WIDTH;

  // Front to queue: one entry per emitting vertex. Vertices are packed as
  // {y, x} so a whole vertex moves as one vector.
  logic          push_valid;
  logic          push_ready;
  logic          push_single;
  logic [VW-1:0] push_a;
  logic [VW-1:0] push_b;
  logic [VW-1:0] push_c;

  // Queue to back: the head entry and its pop strobe.
  tpl_pkg::tpl_head_ctl_t head;
  logic [VW-1:0]          head_a;
  logic [VW-1:0]          head_b;
  logic [VW-1:0]          head_c;
  logic                   pop;

  // The front owns all primitive state (mode, pending flags, winding and
  // the held vertices) and decides per vertex whether a triangle, a single
  // vertex or nothing results.
  tpl_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_single (push_single),
    .push_a      (push_a),
    .push_b      (push_b),
    .push_c      (push_c)
  );

  // The queue holds whole triangles so the front can keep going while the
  // back serializes each one into output words.
  tpl_queue #(.COORD_WIDTH(COORD_WIDTH)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_single (push_single),
    .push_a      (push_a),
    .push_b      (push_b),
    .push_c      (push_c),
    .head        (head),
    .head_a      (head_a),
    .head_b      (head_b),
    .head_c      (head_c),
    .pop         (pop)
  );

  // The back serializes the head entry into output words and marks the
  // final word of each entry with last.
  tpl_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .head_a (head_a),
    .head_b (head_b),
    .head_c (head_c),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tpl_checker.sv
// Port-level checker for the triangle primitive assembler and its binding.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps
`default_nettype none

module tpl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_cmd,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);

  logic [1:0] run;   // non-last words delivered since the last last word
  logic       seen;  // some vertex word has been accepted since reset

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 2'd0;
      seen <= 1'b0;
    end else begin
      if (in_valid && in_ready && in_cmd) begin
        seen <= 1'b1;
      end
      if (out_valid && out_ready) begin
        run <= out_last ? 2'd0 : ((run == 2'd2) ? 2'd2 : run + 2'd1);
      end
    end
  end

  // A word offered on the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn before it was taken");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // No output appears before any vertex has come in.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seen)
    else $error("output word without any accepted vertex");

  // A triangle is at most three words: the third is always last.
  a_tri_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (run == 2'd2) |-> out_last)
    else $error("more than three words without last");

endmodule

bind triangle_primitive_to_list tpl_checker u_tpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the triangle primitive assembler.
// Depends on tpl_pkg, tpl_if and triangle_primitive_to_list;
// drives random words over idling phases.
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = tpl_pkg::COORD_WIDTH_DEFAULT;

  // The run is over after this many clocks no matter what.
  localparam int CYCLE_LIMIT = 200000;

  // Length of the long output hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES = 300;

  // Cycles to wait once everything expected has arrived.
  localparam int SETTLE_CYCLES = 12;

  // Only this many mismatches are printed. Later ones are only counted.
  localparam int MAX_REPORTS = 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } coord_pair_t;

  // One input word as offered on in_ch.
  typedef struct {
    logic       cmd;
    logic [1:0] prim_type;
    coord_t     x;
    coord_t     y;
  } in_word_t;

  // One triangle-list vertex as it should appear on out_ch.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } list_vertex_t;

  logic clk;
  logic rst = 1'b1;

  tpl_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  tpl_out_if #(.COORD_WIDTH(CW)) out_ch ();

  triangle_primitive_to_list #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The clock toggles every 5 ns, so the period is 10 ns.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Words that wait to be driven, and the list vertices that the assembler should produce,
  // oldest first.
  in_word_t     pending_words[$];
  list_vertex_t list_vertices_due[$];

  // These knobs are set from the sequencer at the falling edge, so they never race the
  // clocked processes that read them.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;

  // Counters for checking and for the summary.
  int error_count = 0;
  int words_accepted = 0;
  int vertices_checked = 0;
  int groups_closed = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor state. It mirrors what the assembler must remember between words. After reset
  // the mode is unsupported, so vertices are dropped until a begin word arrives.
  // ---------------------------------------------------------------------------------------
  logic [1:0]  asm_mode = tpl_pkg::MODE_NONE;
  logic        fan_need_origin = 1'b0;
  logic        fan_need_prev = 1'b0;
  logic        strip_need_older = 1'b0;
  logic        strip_need_prev = 1'b0;
  logic        strip_flip = 1'b0;
  coord_pair_t origin_v = '0;
  coord_pair_t prev_v = '0;
  coord_pair_t older_v = '0;

  function automatic void due_push(coord_pair_t v, logic is_last);
    list_vertex_t e;
    e.x = v.x;
    e.y = v.y;
    e.last = is_last;
    list_vertices_due.insert(list_vertices_due.size(), e);
  endfunction

  function automatic void due_triangle(coord_pair_t a, coord_pair_t b, coord_pair_t c);
    due_push(a, 1'b0);
    due_push(b, 1'b0);
    due_push(c, 1'b1);
  endfunction

  // Works out the list vertices that one accepted word produces and updates the assembler
  // state to match.
  function automatic void assemble_word(in_word_t w);
    coord_pair_t v;
    v.x = w.x;
    v.y = w.y;
    if (w.cmd == tpl_pkg::CMD_BEGIN) begin
      // A begin word emits nothing. Fan and strip restart their own phase. Triangles and
      // unsupported leave the held phases alone.
      asm_mode = w.prim_type;
      if (w.prim_type == tpl_pkg::MODE_FAN) begin
        fan_need_origin = 1'b1;
        fan_need_prev = 1'b0;
      end else if (w.prim_type == tpl_pkg::MODE_STRIP) begin
        strip_need_older = 1'b1;
        strip_need_prev = 1'b0;
        strip_flip = 1'b0;
      end
    end else begin
      case (asm_mode)
        tpl_pkg::MODE_TRIANGLES: begin
          due_push(v, 1'b1);
        end
        tpl_pkg::MODE_FAN: begin
          if (fan_need_origin) begin
            origin_v = v;
            fan_need_origin = 1'b0;
            fan_need_prev = 1'b1;
          end else if (fan_need_prev) begin
            prev_v = v;
            fan_need_prev = 1'b0;
          end else begin
            due_triangle(origin_v, prev_v, v);
            prev_v = v;
          end
        end
        tpl_pkg::MODE_STRIP: begin
          if (strip_need_older) begin
            older_v = v;
            strip_need_older = 1'b0;
            strip_need_prev = 1'b1;
          end else if (strip_need_prev) begin
            prev_v = v;
            strip_need_prev = 1'b0;
          end else begin
            // The winding swaps on every second triangle so that all faces keep one
            // orientation.
            if (strip_flip) begin
              due_triangle(prev_v, older_v, v);
            end else begin
              due_triangle(older_v, prev_v, v);
            end
            older_v = prev_v;
            prev_v = v;
            strip_flip = ~strip_flip;
          end
        end
        default: begin
          // In unsupported mode vertices are dropped and nothing is emitted.
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus generation. The generator tracks the mode on its own, so that vertices that the
  // block simply drops do not count toward the number of items.
  // ---------------------------------------------------------------------------------------
  logic [1:0] gen_mode = tpl_pkg::MODE_NONE;
  int         gen_counted = 0;

  function automatic void queue_word(logic cmd, logic [1:0] pt, coord_t x, coord_t y);
    in_word_t w;
    w.cmd = cmd;
    w.prim_type = pt;
    w.x = x;
    w.y = y;
    pending_words.insert(pending_words.size(), w);
    if (cmd == tpl_pkg::CMD_BEGIN) begin
      gen_mode = pt;
      gen_counted++;
    end else if (gen_mode != tpl_pkg::MODE_NONE) begin
      gen_counted++;
    end
  endfunction

  // Returns a coordinate word. Extremes come up often, and any other value is uniform.
  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(0, 7))
      0: c = {1'b1, {(CW-1){1'b0}}};
      1: c = {1'b0, {(CW-1){1'b1}}};
      2: c = '0;
      3: c = '1;
      default: c = coord_t'($urandom);
    endcase
    return c;
  endfunction

  // Most of the traffic is well-formed: a begin word followed by a run of vertices. The rest
  // is noise, that is stray begins of any type and vertices that continue whatever mode is
  // current.
  task automatic queue_random_words(int n);
    int         target;
    int         run_len;
    int         pick;
    logic [1:0] pt;
    target = gen_counted + n;
    while (gen_counted < target) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_word(logic'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   rand_coord(), rand_coord());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          pt = tpl_pkg::MODE_TRIANGLES;
        end else if (pick < 55) begin
          pt = tpl_pkg::MODE_FAN;
        end else if (pick < 92) begin
          pt = tpl_pkg::MODE_STRIP;
        end else begin
          pt = tpl_pkg::MODE_NONE;
        end
        queue_word(tpl_pkg::CMD_BEGIN, pt, rand_coord(), rand_coord());
        run_len = $urandom_range(1, 9);
        repeat (run_len) begin
          queue_word(tpl_pkg::CMD_VERTEX, 2'($urandom_range(0, 3)), rand_coord(),
                     rand_coord());
        end
      end
    end
  endtask

  // Short directed opening that covers the extremes and every mode.
  task automatic queue_directed_words();
    coord_t cmin;
    coord_t cmax;
    cmin = {1'b1, {(CW-1){1'b0}}};
    cmax = {1'b0, {(CW-1){1'b1}}};
    // A vertex straight after reset lands in unsupported mode and is dropped.
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_TRIANGLES, 32'sd11, 32'sd12);
    // On a begin word the vertex fields must be ignored.
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_TRIANGLES, cmax, cmin);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_TRIANGLES, cmin, cmax);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_NONE, cmax, cmin);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_STRIP, '0, '1);
    // Four fan vertices produce two triangles that share the origin.
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_FAN, '1, '1);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_FAN, 32'sd100, -32'sd100);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_TRIANGLES, cmin, cmin);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_NONE, cmax, cmax);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_STRIP, 32'sd7, 32'sd8);
    // Five strip vertices produce three triangles, and the middle one has its winding swapped.
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_STRIP, '0, '0);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_STRIP, 32'sd1, 32'sd2);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_STRIP, 32'sd3, 32'sd4);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_STRIP, 32'sd5, 32'sd6);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_FAN, cmax, '1);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_NONE, cmin, '0);
    // An unsupported begin drops the vertices that follow it.
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_NONE, cmax, cmax);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_TRIANGLES, 32'sd9, 32'sd9);
    // A fan cut short after two vertices emits nothing, and triangles take over.
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_FAN, '0, '0);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_FAN, 32'sd21, 32'sd22);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_FAN, 32'sd23, 32'sd24);
    queue_word(tpl_pkg::CMD_BEGIN, tpl_pkg::MODE_TRIANGLES, '0, '0);
    queue_word(tpl_pkg::CMD_VERTEX, tpl_pkg::MODE_TRIANGLES, '1, cmin);
  endtask

  // Waits at the falling edge until every word has gone in and every expected vertex has come
  // out, then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || list_vertices_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver. A word that has been offered stays on the bus until it is taken. The prediction
  // is made at the edge where the word is accepted, from the values the block sampled. The
  // valid signal gets at most one assignment per edge. Reset puts every input of the block at
  // a known value.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    in_word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= tpl_pkg::CMD_BEGIN;
      in_ch.prim_type <= tpl_pkg::MODE_NONE;
      in_ch.vertex_x <= '0;
      in_ch.vertex_y <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        w.cmd = in_ch.cmd;
        w.prim_type = in_ch.prim_type;
        w.x = in_ch.vertex_x;
        w.y = in_ch.vertex_y;
        assemble_word(w);
        words_accepted++;
      end
      if (in_ch.valid && !in_ch.ready && hold_left != 0) begin
        input_stall_cycles++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_ch.cmd <= w.cmd;
          in_ch.prim_type <= w.prim_type;
          in_ch.vertex_x <= w.x;
          in_ch.vertex_y <= w.y;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off counts down on its own. While it runs, the output is never ready.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The receiver is ready unless a random stall or the long hold-off is in force.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. Each accepted output word is checked field by field against the oldest
  // expected list vertex.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : list_monitor
    list_vertex_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (list_vertices_due.size() == 0) begin
        flag_error($sformatf("unexpected vertex x=%h y=%h last=%b",
                             out_ch.out_x, out_ch.out_y, out_ch.last));
      end else begin
        e = list_vertices_due.pop_front();
        vertices_checked++;
        if (e.last) begin
          groups_closed++;
        end
        if (out_ch.out_x !== e.x || out_ch.out_y !== e.y || out_ch.last !== e.last) begin
          flag_error($sformatf("expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                               e.x, e.y, e.last, out_ch.out_x, out_ch.out_y, out_ch.last));
        end
      end
    end
  end

  // The watchdog stops a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d vertices outstanding",
               cycle_count, list_vertices_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer. Reset is followed by one phase per idling pattern and then the back-pressure
  // phase. The knobs are changed only at the falling edge.
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // In the first phase neither side idles.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_directed_words();
    queue_random_words(55);
    wait_drained();

    // In the next phase only the sender idles.
    send_idle_pct = 45;
    recv_stall_pct = 0;
    queue_random_words(60);
    wait_drained();

    // Then only the receiver stalls.
    send_idle_pct = 0;
    recv_stall_pct = 45;
    queue_random_words(60);
    wait_drained();

    // Then both sides idle at once.
    send_idle_pct = 38;
    recv_stall_pct = 38;
    queue_random_words(60);
    wait_drained();

    // Last comes the long hold-off on the output while the sender keeps offering words, so
    // that the queue fills and the input stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    queue_random_words(50);
    wait_drained();

    if (list_vertices_due.size() != 0) begin
      flag_error($sformatf("%0d expected vertices never arrived", list_vertices_due.size()));
    end

    $display("Summary: %0d words accepted in five idling phases, %0d list vertices checked",
             words_accepted, vertices_checked);
    $display("Summary: %0d emitting words, input held off %0d cycles under output hold-off",
             groups_closed, input_stall_cycles);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
